[src/cgil_pkg.sv]
// Shared constants for the character-map glyph index lookup unit.
// Used by cmap_glyph_index_lookup_unit; no dependencies.
`default_nettype none
package cgil_pkg;

  // Table memory geometry
  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned WORD_W      = 16;

  // Request field widths
  localparam int unsigned WADDR_W = 12;
  localparam int unsigned CP_W    = 16;

  // Segment count is half of table word 0
  localparam int unsigned SEG_W = WORD_W - 1;
  // Wide enough for 3*S + 5 + i and for the range-offset fetch address
  localparam int unsigned EXT_W = 18;

  // Layout offsets of format four
  localparam int unsigned END_OFS  = 4;
  localparam int unsigned BASE_OFS = 5;

  // Highest code point served in byte-table mode
  localparam int unsigned BYTE_MAX = 255;

  // Request function codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Configuration register indexes
  localparam logic REG_MODE = 1'b0;

  // APB port geometry
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

endpackage
`default_nettype wire

[src/cgil_ram.sv]
// Single-port synchronous table RAM with a registered read port.
// Read data holds while no read is issued. No package dependencies.
`default_nettype none
module cgil_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[src/cmap_glyph_index_lookup_unit.sv]
// Character-map glyph index lookup unit (cmap format 0 and format 4).
// Depends on cgil_pkg and cgil_ram.
// Write request: written when accepted, next request accepted in the following cycle.
// Byte-table lookup: one table read, none above code point 255;
// segmented lookup: header, then end and start words per segment scanned, then
// delta, range offset and, if needed, glyph words through the single RAM port. One
// request is in flight at a time. Reset clears control state and the mode register;
// the table is undefined until written.
`default_nettype none
module cmap_glyph_index_lookup_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Request channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          func_i,
  input  wire logic [cgil_pkg::WADDR_W-1:0]  word_addr_i,
  input  wire logic [cgil_pkg::WORD_W-1:0]   word_data_i,
  input  wire logic [cgil_pkg::CP_W-1:0]     code_point_i,
  // Result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [cgil_pkg::WORD_W-1:0]   glyph_index_o,
  output logic                               found_o,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cgil_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [cgil_pkg::PDATA_W-1:0]  pwdata,
  output logic      [cgil_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  localparam int unsigned AW = cgil_pkg::ADDR_W;
  localparam int unsigned XW = cgil_pkg::EXT_W;
  localparam int unsigned SW = cgil_pkg::SEG_W;
  localparam int unsigned DW = cgil_pkg::WORD_W;
  localparam logic [XW-1:0] DEPTH_X = XW'(cgil_pkg::TABLE_DEPTH);
  localparam int unsigned CP_W_LOCAL = cgil_pkg::CP_W;
  localparam logic [CP_W_LOCAL-1:0] CP_W_BYTE_MAX = CP_W_LOCAL'(cgil_pkg::BYTE_MAX);

  // Sequencer state codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_BYTE  = 4'd1;
  localparam logic [3:0] ST_HDR   = 4'd2;
  localparam logic [3:0] ST_END   = 4'd3;
  localparam logic [3:0] ST_START = 4'd4;
  localparam logic [3:0] ST_CMP   = 4'd5;
  localparam logic [3:0] ST_DELTA = 4'd6;
  localparam logic [3:0] ST_RO    = 4'd7;
  localparam logic [3:0] ST_CHK   = 4'd8;
  localparam logic [3:0] ST_GLY   = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  // Configuration register
  logic mode_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_wr && (paddr[2] == cgil_pkg::REG_MODE)) begin
      mode_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == cgil_pkg::REG_MODE) begin
      prdata = {{(cgil_pkg::PDATA_W-1){1'b0}}, mode_q};
    end
  end

  // Sequencer registers
  logic [3:0]      state_q, state_d;
  logic [DW-1:0]   cp_q, cp_d;
  logic [SW-1:0]   segs_q, segs_d;
  logic [SW-1:0]   idx_q, idx_d;
  logic [XW-1:0]   ro_base_q, ro_base_d;
  logic [AW-1:0]   ro_addr_q, ro_addr_d;
  logic [DW-1:0]   end_q, end_d;
  logic [DW-1:0]   start_q, start_d;
  logic [DW-1:0]   delta_q, delta_d;
  logic [XW-1:0]   fa_q, fa_d;
  logic [DW-1:0]   res_glyph_q, res_glyph_d;
  logic            res_found_q, res_found_d;

  // Output register
  logic            out_valid_q;
  logic [DW-1:0]   out_glyph_q;
  logic            out_found_q;
  logic            out_free;
  logic            out_load;

  // RAM port
  logic            ram_we;
  logic            ram_re;
  logic [AW-1:0]   ram_addr;
  logic [DW-1:0]   ram_rdata;

  // Datapath helpers
  logic            in_acc;
  logic [XW-1:0]   wr_addr_x;
  logic [XW-1:0]   ro_addr_x;
  logic [XW-1:0]   end_addr_x;
  logic [XW-1:0]   start_addr_x;
  logic [XW-1:0]   delta_addr_x;
  logic [XW-1:0]   hdr_segs_x;
  logic [DW-1:0]   cp_minus_start;
  logic [DW-1:0]   cp_plus_delta;
  logic [DW-1:0]   gly_plus_delta;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_OUT) && out_free;

  assign wr_addr_x      = XW'(word_addr_i);
  assign ro_addr_x      = ro_base_q + XW'(idx_q);
  assign end_addr_x     = XW'(cgil_pkg::END_OFS) + XW'(idx_q);
  assign start_addr_x   = XW'(segs_q) + XW'(cgil_pkg::BASE_OFS) + XW'(idx_q);
  assign delta_addr_x   = (XW'(segs_q) << 1) + XW'(cgil_pkg::BASE_OFS) + XW'(idx_q);
  assign hdr_segs_x     = XW'(ram_rdata[DW-1:1]);
  assign cp_minus_start = cp_q - start_q;
  assign cp_plus_delta  = cp_q + delta_q;
  assign gly_plus_delta = ram_rdata + delta_q;

  // Lookup sequencer: at most one RAM access per cycle
  always_comb begin
    state_d     = state_q;
    cp_d        = cp_q;
    segs_d      = segs_q;
    idx_d       = idx_q;
    ro_base_d   = ro_base_q;
    ro_addr_d   = ro_addr_q;
    end_d       = end_q;
    start_d     = start_q;
    delta_d     = delta_q;
    fa_d        = fa_q;
    res_glyph_d = res_glyph_q;
    res_found_d = res_found_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cp_d = code_point_i;
          if (func_i == cgil_pkg::FUNC_WRITE) begin
            // table word write; addresses past the table are dropped
            ram_addr = wr_addr_x[AW-1:0];
            ram_we   = (wr_addr_x < DEPTH_X);
          end else if (!mode_q) begin
            if (code_point_i <= CP_W_BYTE_MAX) begin
              ram_re   = 1'b1;
              ram_addr = AW'(code_point_i);
              state_d  = ST_BYTE;
            end else begin
              res_glyph_d = '0;
              res_found_d = 1'b0;
              state_d     = ST_OUT;
            end
          end else begin
            // header word holds twice the segment count
            ram_re   = 1'b1;
            ram_addr = '0;
            state_d  = ST_HDR;
          end
        end
      end
      ST_BYTE: begin
        res_glyph_d = {{(DW-8){1'b0}}, ram_rdata[7:0]};
        res_found_d = 1'b1;
        state_d     = ST_OUT;
      end
      ST_HDR: begin
        segs_d    = ram_rdata[DW-1:1];
        idx_d     = '0;
        ro_base_d = hdr_segs_x + (hdr_segs_x << 1) + XW'(cgil_pkg::BASE_OFS);
        state_d   = ST_END;
      end
      ST_END: begin
        // scan ends at the segment count or where segments leave the table
        if ((idx_q >= segs_q) || (ro_addr_x >= DEPTH_X)) begin
          res_glyph_d = '0;
          res_found_d = 1'b0;
          state_d     = ST_OUT;
        end else begin
          ro_addr_d = ro_addr_x[AW-1:0];
          ram_re    = 1'b1;
          ram_addr  = end_addr_x[AW-1:0];
          state_d   = ST_START;
        end
      end
      ST_START: begin
        end_d    = ram_rdata;
        ram_re   = 1'b1;
        ram_addr = start_addr_x[AW-1:0];
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        if ((cp_q > end_q) || (cp_q < ram_rdata)) begin
          idx_d   = idx_q + SW'(1);
          state_d = ST_END;
        end else begin
          start_d  = ram_rdata;
          ram_re   = 1'b1;
          ram_addr = delta_addr_x[AW-1:0];
          state_d  = ST_DELTA;
        end
      end
      ST_DELTA: begin
        delta_d  = ram_rdata;
        ram_re   = 1'b1;
        ram_addr = ro_addr_q;
        state_d  = ST_RO;
      end
      ST_RO: begin
        if (ram_rdata == '0) begin
          res_glyph_d = cp_plus_delta;
          res_found_d = 1'b1;
          state_d     = ST_OUT;
        end else begin
          fa_d    = XW'(ro_addr_q) + XW'(ram_rdata[DW-1:1]) + XW'(cp_minus_start);
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (fa_q >= DEPTH_X) begin
          res_glyph_d = '0;
          res_found_d = 1'b0;
          state_d     = ST_OUT;
        end else begin
          ram_re   = 1'b1;
          ram_addr = fa_q[AW-1:0];
          state_d  = ST_GLY;
        end
      end
      ST_GLY: begin
        // a fetched zero stays zero, without delta
        res_glyph_d = (ram_rdata == '0) ? '0 : gly_plus_delta;
        res_found_d = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    cp_q        <= cp_d;
    segs_q      <= segs_d;
    idx_q       <= idx_d;
    ro_base_q   <= ro_base_d;
    ro_addr_q   <= ro_addr_d;
    end_q       <= end_d;
    start_q     <= start_d;
    delta_q     <= delta_d;
    fa_q        <= fa_d;
    res_glyph_q <= res_glyph_d;
    res_found_q <= res_found_d;
  end

  // Output register parts the result side from the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_glyph_q <= res_glyph_q;
      out_found_q <= res_found_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign glyph_index_o = out_glyph_q;
  assign found_o       = out_found_q;

  // Table memory
  cgil_ram #(
    .DEPTH (cgil_pkg::TABLE_DEPTH),
    .WIDTH (cgil_pkg::WORD_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (word_data_i),
    .rdata_o (ram_rdata)
  );

  // Checks
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> glyph_index_o == '0)
    else $error("unmapped result carries a nonzero glyph");

  a_byte_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mode_q && found_o |-> glyph_index_o[DW-1:8] == '0)
    else $error("byte-table result above one byte");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_END |-> idx_q <= segs_q)
    else $error("segment index ran past the segment count");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == ST_IDLE && in_acc)
    else $error("table write outside an accepted write request");

endmodule
`default_nettype wire
